### sv/jpeg_scan_header_parser_macros.svh
// Assertion macros used by the scan header parser top level.
`ifndef JPEG_SCAN_HEADER_PARSER_MACROS_SVH
`define JPEG_SCAN_HEADER_PARSER_MACROS_SVH

// Check cons in the same cycle as ante.
`define JSH_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define JSH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/jsh_pkg.sv
// Types, codes and constants of the scan header parser.
package jsh_pkg;

    localparam int MAX_COMP_DEF = 4;
    localparam int SLOT_COUNT   = 4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_COUNT = 3'd1;
    localparam logic [2:0] ST_BAD_LEN   = 3'd2;
    localparam logic [2:0] ST_BAD_ID    = 3'd3;
    localparam logic [2:0] ST_BAD_COEFF = 3'd4;

    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_LEN_LO   = 3'd1;
    localparam logic [2:0] PH_COUNT    = 3'd2;
    localparam logic [2:0] PH_COMP_ID  = 3'd3;
    localparam logic [2:0] PH_COMP_TBL = 3'd4;
    localparam logic [2:0] PH_SS       = 3'd5;
    localparam logic [2:0] PH_SE       = 3'd6;
    localparam logic [2:0] PH_APPROX   = 3'd7;

    localparam logic [2:0] REG_FRAME_COUNT = 3'd0;
    localparam logic [2:0] REG_COMP_ID_0   = 3'd1;

    localparam logic [7:0]  SCAN_COUNT_MAX = 8'd4;
    localparam logic [15:0] LEN_BIAS       = 16'd6;
    localparam logic [7:0]  COEFF_LAST     = 8'd63;

    typedef struct packed {
        logic [7:0] seg_byte;
        logic       seg_start;
    } in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  scan_comp_count;
        logic [3:0]  comp_mask;
        logic [15:0] dc_tables;
        logic [15:0] ac_tables;
        logic [7:0]  first_coeff;
        logic [7:0]  last_coeff;
        logic [3:0]  approx_high;
        logic [3:0]  approx_low;
        logic        interleaved;
    } out_t;

    typedef struct packed {
        logic       hit;
        logic [1:0] slot;
    } match_t;

endpackage

### sv/jsh_id_match.sv
// Component id lookup against the frame component table.
module jsh_id_match #(
    parameter int MAX_COMPONENTS = jsh_pkg::MAX_COMP_DEF
) (
    input  logic [7:0]      id_byte,
    input  logic [2:0]      frame_count,
    input  logic [2:0]      position,
    input  logic [7:0]      ids [MAX_COMPONENTS],
    output jsh_pkg::match_t match
);
    import jsh_pkg::*;

    always_comb
    begin
        logic       pref;
        logic       low_hit;
        logic [1:0] low_slot;
        pref     = 1'b0;
        low_hit  = 1'b0;
        low_slot = 2'd0;
        for (int j = MAX_COMPONENTS - 1; j >= 0; j--)
        begin
            if (3'(j) < frame_count && ids[j] == id_byte)
            begin
                low_hit  = 1'b1;
                low_slot = 2'(j);
                if (position == 3'(j))
                begin
                    pref = 1'b1;
                end
            end
        end
        match.hit  = low_hit;
        match.slot = pref ? position[1:0] : low_slot;
    end

endmodule

### sv/jpeg_scan_header_parser.sv
// Top level of the JPEG start-of-scan header parser.
// Takes one segment byte per cycle: every byte is decoded in the cycle it is
// accepted, from the parse phase and the recorded fields, and the one result
// per segment (on the approximation byte or on the first failed check) is
// loaded into an output register. in_ready is low only while that register
// holds a result and out_ready is low; otherwise a byte is taken every cycle.
// Configuration writes take effect at the next clock edge.
module jpeg_scan_header_parser #(
    parameter int MAX_COMPONENTS = jsh_pkg::MAX_COMP_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  jsh_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output jsh_pkg::out_t out_data,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [7:0]    cfg_data
);
    import jsh_pkg::*;

    `include "jpeg_scan_header_parser_macros.svh"

    logic [2:0]  frame_count_reg;
    logic [7:0]  ids_reg [MAX_COMPONENTS];

    logic [2:0]  phase_reg, phase_next;
    logic [15:0] length_reg, length_next;
    logic [2:0]  count_reg, count_next;
    logic [2:0]  counter_reg, counter_next;
    logic [1:0]  slot_reg, slot_next;
    logic [3:0]  mask_reg, mask_next;
    logic [15:0] dc_reg, dc_next;
    logic [15:0] ac_reg, ac_next;
    logic [7:0]  ss_reg, ss_next;
    logic [7:0]  se_reg, se_next;

    logic        out_valid_reg, out_valid_next;
    out_t        out_data_reg, out_data_next;

    logic        in_fire;
    logic        emit;
    logic [2:0]  emit_status;
    logic [7:0]  approx_byte;
    match_t      match;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    jsh_id_match #(
        .MAX_COMPONENTS(MAX_COMPONENTS)
    ) u_id_match (
        .id_byte    (in_data.seg_byte),
        .frame_count(frame_count_reg),
        .position   (counter_reg),
        .ids        (ids_reg),
        .match      (match)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= 3'd1;
            for (int j = 0; j < MAX_COMPONENTS; j++)
            begin
                ids_reg[j] <= 8'd0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_FRAME_COUNT)
            begin
                frame_count_reg <= cfg_data[2:0];
            end
            for (int j = 0; j < MAX_COMPONENTS; j++)
            begin
                if (cfg_index == REG_COMP_ID_0 + 3'(j))
                begin
                    ids_reg[j] <= cfg_data;
                end
            end
        end
    end

    always_comb
    begin
        logic [7:0] b;
        b            = in_data.seg_byte;
        phase_next   = phase_reg;
        length_next  = length_reg;
        count_next   = count_reg;
        counter_next = counter_reg;
        slot_next    = slot_reg;
        mask_next    = mask_reg;
        dc_next      = dc_reg;
        ac_next      = ac_reg;
        ss_next      = ss_reg;
        se_next      = se_reg;
        emit         = 1'b0;
        emit_status  = ST_OK;
        approx_byte  = 8'd0;
        if (in_fire)
        begin
            if (in_data.seg_start)
            begin
                length_next  = {b, 8'd0};
                count_next   = 3'd0;
                counter_next = 3'd0;
                slot_next    = 2'd0;
                mask_next    = 4'd0;
                dc_next      = 16'd0;
                ac_next      = 16'd0;
                ss_next      = 8'd0;
                se_next      = 8'd0;
                phase_next   = PH_LEN_LO;
            end
            else
            begin
                unique case (phase_reg)
                    PH_LEN_LO:
                    begin
                        length_next = {length_reg[15:8], b};
                        phase_next  = PH_COUNT;
                    end
                    PH_COUNT:
                    begin
                        if (b == 8'd0 || b > SCAN_COUNT_MAX)
                        begin
                            count_next  = 3'd0;
                            emit        = 1'b1;
                            emit_status = ST_BAD_COUNT;
                        end
                        else
                        begin
                            count_next = b[2:0];
                            if (length_reg != {7'd0, b, 1'b0} + LEN_BIAS)
                            begin
                                emit        = 1'b1;
                                emit_status = ST_BAD_LEN;
                            end
                            else
                            begin
                                counter_next = 3'd0;
                                phase_next   = PH_COMP_ID;
                            end
                        end
                    end
                    PH_COMP_ID:
                    begin
                        if (!match.hit)
                        begin
                            emit        = 1'b1;
                            emit_status = ST_BAD_ID;
                        end
                        else
                        begin
                            slot_next             = match.slot;
                            mask_next[match.slot] = 1'b1;
                            phase_next            = PH_COMP_TBL;
                        end
                    end
                    PH_COMP_TBL:
                    begin
                        for (int s = 0; s < SLOT_COUNT; s++)
                        begin
                            if (slot_reg == 2'(s))
                            begin
                                dc_next[s*4 +: 4] = b[7:4];
                                ac_next[s*4 +: 4] = b[3:0];
                            end
                        end
                        counter_next = counter_reg + 3'd1;
                        phase_next   = (counter_next >= count_reg) ? PH_SS : PH_COMP_ID;
                    end
                    PH_SS:
                    begin
                        ss_next    = b;
                        phase_next = PH_SE;
                    end
                    PH_SE:
                    begin
                        se_next = b;
                        if (b > COEFF_LAST || ss_reg > b)
                        begin
                            emit        = 1'b1;
                            emit_status = ST_BAD_COEFF;
                        end
                        else
                        begin
                            phase_next = PH_APPROX;
                        end
                    end
                    PH_APPROX:
                    begin
                        emit        = 1'b1;
                        emit_status = ST_OK;
                        approx_byte = b;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
                if (emit)
                begin
                    phase_next = PH_IDLE;
                end
            end
        end
    end

    always_comb
    begin
        out_data_next.status          = emit_status;
        out_data_next.scan_comp_count = count_next;
        out_data_next.comp_mask       = mask_next;
        out_data_next.dc_tables       = dc_next;
        out_data_next.ac_tables       = ac_next;
        out_data_next.first_coeff     = ss_next;
        out_data_next.last_coeff      = se_next;
        out_data_next.approx_high     = approx_byte[7:4];
        out_data_next.approx_low      = approx_byte[3:0];
        out_data_next.interleaved     = (count_next != 3'd0) && (count_next == frame_count_reg);
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            length_reg    <= 16'd0;
            count_reg     <= 3'd0;
            counter_reg   <= 3'd0;
            slot_reg      <= 2'd0;
            mask_reg      <= 4'd0;
            dc_reg        <= 16'd0;
            ac_reg        <= 16'd0;
            ss_reg        <= 8'd0;
            se_reg        <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            length_reg    <= length_next;
            count_reg     <= count_next;
            counter_reg   <= counter_next;
            slot_reg      <= slot_next;
            mask_reg      <= mask_next;
            dc_reg        <= dc_next;
            ac_reg        <= ac_next;
            ss_reg        <= ss_next;
            se_reg        <= se_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_data_reg <= out_data_next;
        end
    end

    `JSH_ASSERT_SAME(a_ok_count,
        out_valid_reg && out_data_reg.status == ST_OK,
        out_data_reg.scan_comp_count != 3'd0 && out_data_reg.scan_comp_count <= 3'd4,
        "ok transaction with scan count out of range")
    `JSH_ASSERT_SAME(a_bad_count_clear,
        out_valid_reg && out_data_reg.status == ST_BAD_COUNT,
        out_data_reg.scan_comp_count == 3'd0 && out_data_reg.comp_mask == 4'd0,
        "bad count transaction carries recorded fields")
    `JSH_ASSERT_NEXT(a_start_len,
        in_fire && in_data.seg_start,
        phase_reg == PH_LEN_LO && count_reg == 3'd0 && mask_reg == 4'd0,
        "segment start did not restart parsing")
    `JSH_ASSERT_NEXT(a_emit_idle,
        emit,
        phase_reg == PH_IDLE && out_valid_reg,
        "result emitted without returning to idle")

endmodule
